// ----- hw/rtl/fohs_pkg.sv -----
`default_nettype none
package fohs_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int LEN_W          = 16;
  localparam int QW             = 8;
  localparam int QDEPTH         = 2;
  localparam int PADDR_W        = 3;
  localparam logic [LEN_W-1:0] DEFAULT_LEN = 16'd30;
  localparam logic [15:0]      SPEED_ONE   = 16'd256;
  localparam logic [8:0]       PROG_FULL   = 9'd256;

  // command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_START_OUT = 3'd1;
  localparam logic [2:0] CMD_START_IN  = 3'd2;
  localparam logic [2:0] CMD_SKIP      = 3'd3;
  localparam logic [2:0] CMD_RESET     = 3'd4;

  // phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_OUT  = 2'd1;
  localparam logic [1:0] PH_HOLD = 2'd2;
  localparam logic [1:0] PH_IN   = 2'd3;

  // register indexes
  localparam logic REG_HOLD  = 1'b0;
  localparam logic REG_SPEED = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START_OUT,
    OP_START_IN,
    OP_SKIP,
    OP_RESET,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] duration;
  } in_word_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [8:0] progress;
    logic [1:0] phase;
    logic       callback_fired;
  } out_word_t;

  typedef struct packed {
    op_t              op;
    logic [LEN_W-1:0] len;
  } qentry_t;

  typedef struct packed {
    logic    valid;
    qentry_t e;
  } qhead_t;

  typedef struct packed {
    logic [15:0] hold_length;
    logic [15:0] speed;
  } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/fohs_front.sv -----
`default_nettype none
module fohs_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  fohs_pkg::in_word_t cmd_word,
  input  logic               pop,
  output fohs_pkg::qhead_t   head
);
  import fohs_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  qentry_t        mem [QDEPTH];
  qentry_t        entry;
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;

  always_comb begin
    entry.len = (cmd_word.duration == '0) ? DEFAULT_LEN : cmd_word.duration;
    unique case (cmd_word.cmd)
      CMD_TICK:      entry.op = OP_TICK;
      CMD_START_OUT: entry.op = OP_START_OUT;
      CMD_START_IN:  entry.op = OP_START_IN;
      CMD_SKIP:      entry.op = OP_SKIP;
      CMD_RESET:     entry.op = OP_RESET;
      default:       entry.op = OP_NONE;
    endcase
  end

  assign cmd_stall  = (count == (QAW+1)'(QDEPTH));
  assign push       = cmd_valid && !cmd_stall;
  assign head.valid = (count != '0);
  assign head.e     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fohs_div.sv -----
`default_nettype none
module fohs_div #(
  parameter int RW = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [RW-1:0]         dividend,
  input  logic [RW-1:0]         divisor,
  output logic                  done,
  output logic [fohs_pkg::QW-1:0] quotient,
  output logic                  rem_nz
);
  import fohs_pkg::*;

  localparam int CW = $clog2(QW);

  logic [RW-1:0] rem;
  logic [RW-1:0] dsh;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          ge;

  assign ge     = (rem >= dsh);
  assign rem_nz = (rem != '0);

  // restoring division, one quotient bit a cycle, quotient known to fit QW bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsh      <= divisor << (QW - 1);
      quotient <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh;
      end
      quotient <= {quotient[QW-2:0], ge};
      dsh      <= dsh >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fohs_back.sv -----
`default_nettype none
module fohs_back #(
  parameter int TIMER_BITS = fohs_pkg::TIMER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  fohs_pkg::cfg_t      cfg,
  input  fohs_pkg::qhead_t    head,
  output logic                pop,
  output logic                res_valid,
  input  logic                res_stall,
  output fohs_pkg::out_word_t res_word
);
  import fohs_pkg::*;

  localparam int NUMW = TIMER_BITS + 16;
  localparam int RW   = NUMW + 8;
  localparam int CW   = (TIMER_BITS > LEN_W) ? TIMER_BITS : LEN_W;
  localparam logic [TIMER_BITS-1:0] TMAX = '1;

  typedef enum logic [4:0] {
    ST_WAIT = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIVP = 5'b01000,
    ST_DIVA = 5'b10000
  } st_t;

  st_t                   st, st_next;
  logic [1:0]            phase, phase_next;
  logic [TIMER_BITS-1:0] frame_timer, frame_timer_next;
  logic [LEN_W-1:0]      out_len, out_len_next;
  logic [LEN_W-1:0]      in_len, in_len_next;
  logic [7:0]            alpha, alpha_next;
  logic [8:0]            progress, progress_next;
  logic [NUMW-1:0]       num, num_next;
  out_word_t             res_word_next;
  logic                  wr_out;
  logic                  out_free;
  logic                  fired;
  logic                  fade_done;
  logic [TIMER_BITS-1:0] adv;
  logic [LEN_W-1:0]      cur_len;
  logic [15:0]           spd;
  logic                  div_start;
  logic [RW-1:0]         div_num;
  logic [RW-1:0]         div_den;
  logic                  div_done;
  logic [QW-1:0]         div_q;
  logic                  div_nz;

  fohs_div #(.RW(RW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q),
    .rem_nz   (div_nz)
  );

  assign out_free = !res_valid || !res_stall;
  assign adv      = (frame_timer != TMAX) ? frame_timer + 1'b1 : frame_timer;
  assign cur_len  = (phase == PH_OUT) ? out_len : in_len;
  assign spd      = (cfg.speed == '0) ? SPEED_ONE : cfg.speed;

  always_comb begin
    st_next          = st;
    phase_next       = phase;
    frame_timer_next = frame_timer;
    out_len_next     = out_len;
    in_len_next      = in_len;
    alpha_next       = alpha;
    progress_next    = progress;
    num_next         = num;
    pop              = 1'b0;
    wr_out           = 1'b0;
    fired            = 1'b0;
    fade_done        = 1'b0;
    div_start        = 1'b0;
    div_num          = RW'(num);
    div_den          = RW'(cur_len);
    unique case (st)
      ST_WAIT: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          unique case (head.e.op)
            OP_TICK: begin
              unique case (phase)
                PH_OUT, PH_IN: begin
                  frame_timer_next = adv;
                  st_next          = ST_MUL;
                end
                PH_HOLD: begin
                  frame_timer_next = adv;
                  alpha_next       = 8'd255;
                  progress_next    = PROG_FULL;
                  if (CW'(adv) >= CW'(cfg.hold_length)) begin
                    fired            = 1'b1;
                    phase_next       = PH_IN;
                    frame_timer_next = '0;
                  end
                  wr_out = 1'b1;
                end
                default: begin
                  wr_out = 1'b1;
                end
              endcase
            end
            OP_START_OUT: begin
              phase_next       = PH_OUT;
              out_len_next     = head.e.len;
              frame_timer_next = '0;
              progress_next    = '0;
              wr_out           = 1'b1;
            end
            OP_START_IN: begin
              phase_next       = PH_IN;
              in_len_next      = head.e.len;
              frame_timer_next = '0;
              progress_next    = '0;
              wr_out           = 1'b1;
            end
            OP_SKIP: begin
              unique case (phase)
                PH_OUT: begin
                  fired      = 1'b1;
                  phase_next = PH_IN;
                  if (CW'(in_len) > CW'(TMAX)) begin
                    frame_timer_next = TMAX;
                  end else begin
                    frame_timer_next = TIMER_BITS'(in_len);
                  end
                  alpha_next    = '0;
                  progress_next = PROG_FULL;
                end
                PH_IN: begin
                  phase_next    = PH_IDLE;
                  alpha_next    = '0;
                  progress_next = PROG_FULL;
                end
                PH_HOLD: begin
                  fired         = 1'b1;
                  phase_next    = PH_IDLE;
                  alpha_next    = '0;
                  progress_next = PROG_FULL;
                end
                default: begin
                end
              endcase
              wr_out = 1'b1;
            end
            OP_RESET: begin
              phase_next       = PH_IDLE;
              frame_timer_next = '0;
              alpha_next       = '0;
              progress_next    = '0;
              wr_out           = 1'b1;
            end
            default: begin
              wr_out = 1'b1;
            end
          endcase
        end
      end
      ST_MUL: begin
        num_next = NUMW'(frame_timer) * NUMW'(spd);
        st_next  = ST_CMP;
      end
      ST_CMP: begin
        if (num >= (NUMW'(cur_len) << 8)) begin
          progress_next = PROG_FULL;
          alpha_next    = (phase == PH_OUT) ? 8'd255 : 8'd0;
          fade_done     = 1'b1;
        end else begin
          div_start = 1'b1;
          st_next   = ST_DIVP;
        end
      end
      ST_DIVP: begin
        if (div_done) begin
          progress_next = {1'b0, div_q};
          div_num       = (RW'(num) << 8) - RW'(num);
          div_den       = RW'(cur_len) << 8;
          div_start     = 1'b1;
          st_next       = ST_DIVA;
        end
      end
      ST_DIVA: begin
        if (div_done) begin
          if (phase == PH_OUT) begin
            alpha_next = div_q;
          end else begin
            alpha_next = 8'd255 - div_q - 8'(div_nz);
          end
          fade_done = 1'b1;
        end
      end
      default: begin
        st_next = ST_WAIT;
      end
    endcase

    // end of a fade phase on the raw frame count
    if (fade_done) begin
      st_next = ST_WAIT;
      wr_out  = 1'b1;
      if (CW'(frame_timer) >= CW'(cur_len)) begin
        if (phase == PH_OUT) begin
          if (cfg.hold_length != '0) begin
            phase_next = PH_HOLD;
          end else begin
            fired      = 1'b1;
            phase_next = PH_IN;
          end
          frame_timer_next = '0;
        end else begin
          phase_next    = PH_IDLE;
          alpha_next    = '0;
          progress_next = PROG_FULL;
        end
      end
    end

    res_word_next.alpha          = alpha_next;
    res_word_next.progress       = progress_next;
    res_word_next.phase          = phase_next;
    res_word_next.callback_fired = fired;
  end

  always_ff @(posedge clk) begin
    num <= num_next;
    if (wr_out) begin
      res_word <= res_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= ST_WAIT;
      phase       <= PH_IDLE;
      frame_timer <= '0;
      out_len     <= DEFAULT_LEN;
      in_len      <= DEFAULT_LEN;
      alpha       <= '0;
      progress    <= '0;
      res_valid   <= 1'b0;
    end else begin
      st          <= st_next;
      phase       <= phase_next;
      frame_timer <= frame_timer_next;
      out_len     <= out_len_next;
      in_len      <= in_len_next;
      alpha       <= alpha_next;
      progress    <= progress_next;
      if (wr_out) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/fade_out_hold_in_sequencer_unit.sv -----
// start, skip, reset, idle and hold-tick words are written to the result register as they
// are accepted; a tick in a fade phase goes through multiply, compare and two 8-step serial
// divisions, or only multiply and compare when the fade is already complete
// the back end takes one word at a time; a 2-entry queue lets the front take words meanwhile
// synchronous reset: idle phase, timer and alpha cleared, fade lengths 30, hold 0, speed 1.0
`default_nettype none
module fade_out_hold_in_sequencer_unit #(
  parameter int TIMER_BITS = fohs_pkg::TIMER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fohs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  fohs_pkg::in_word_t           cmd_word,
  output logic                         res_valid,
  input  logic                         res_stall,
  output fohs_pkg::out_word_t          res_word
);
  import fohs_pkg::*;

  cfg_t   cfg;
  qhead_t head;
  logic   pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPEED) ? {16'b0, cfg.speed} : {16'b0, cfg.hold_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_length <= '0;
      cfg.speed       <= SPEED_ONE;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_HOLD:  cfg.hold_length <= pwdata[15:0];
        REG_SPEED: cfg.speed       <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  fohs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .pop       (pop),
    .head      (head)
  );

  fohs_back #(.TIMER_BITS(TIMER_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  a_pop_has_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("back end took a word from an empty queue");

  a_idle_alpha: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.phase == PH_IDLE) |-> (res_word.alpha == 8'd0))
    else $error("idle result with nonzero alpha");

  a_progress_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_word.progress <= PROG_FULL))
    else $error("progress above full scale");

  a_callback_phase: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.callback_fired) |->
      (res_word.phase == PH_IN || res_word.phase == PH_IDLE))
    else $error("callback fired outside a move to fade-in or idle");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import fohs_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_WORDS = 100;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [15:0] TIMER_TOP = 16'hFFFF;
  localparam logic [7:0] ALPHA_FULL = 8'd255;
  localparam logic [2:0] CMD_LAST = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  in_word_t cmd_word = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  out_word_t res_word;

  in_word_t pending_words[$];
  out_word_t expected_results[$];

  logic [1:0] fade_phase;
  logic [15:0] frame_count;
  logic [15:0] out_len;
  logic [15:0] in_len;
  logic [15:0] hold_frames;
  logic [15:0] speed_q8;
  logic [7:0] alpha_now;
  logic [8:0] progress_now;

  int gap_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int words_queued = 0;
  int results_checked = 0;
  int reg_writes = 0;

  always #5 clk = ~clk;

  fade_out_hold_in_sequencer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  task automatic clear_sequencer();
    fade_phase = PH_IDLE;
    frame_count = '0;
    out_len = DEFAULT_LEN;
    in_len = DEFAULT_LEN;
    hold_frames = '0;
    speed_q8 = SPEED_ONE;
    alpha_now = '0;
    progress_now = '0;
  endtask

  task automatic advance_timer();
    if (frame_count != TIMER_TOP) begin
      frame_count = frame_count + 16'd1;
    end
  endtask

  task automatic fade_frame(input logic [15:0] len);
    logic [63:0] spd;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [15:0] l;
    l = (len == 0) ? DEFAULT_LEN : len;
    spd = (speed_q8 == 0) ? SPEED_ONE : speed_q8;
    advance_timer();
    num = frame_count * spd;
    den = l * 64'd256;
    if (num >= den) begin
      progress_now = PROG_FULL;
      alpha_now = (fade_phase == PH_OUT) ? ALPHA_FULL : 8'd0;
    end else begin
      q = num / l;
      progress_now = q[8:0];
      if (fade_phase == PH_OUT) begin
        q = (num * 64'd255) / den;
        alpha_now = q[7:0];
      end else begin
        q = (num * 64'd255 + den - 64'd1) / den;
        alpha_now = ALPHA_FULL - q[7:0];
      end
    end
  endtask

  task automatic step_sequencer(input in_word_t w);
    logic [15:0] dur;
    logic fired;
    fired = 1'b0;
    dur = (w.duration == 0) ? DEFAULT_LEN : w.duration;
    case (w.cmd)
      CMD_TICK: begin
        case (fade_phase)
          PH_OUT: begin
            fade_frame(out_len);
            if (frame_count >= out_len) begin
              if (hold_frames != 0) begin
                fade_phase = PH_HOLD;
              end else begin
                fired = 1'b1;
                fade_phase = PH_IN;
              end
              frame_count = '0;
            end
          end
          PH_HOLD: begin
            advance_timer();
            alpha_now = ALPHA_FULL;
            progress_now = PROG_FULL;
            if (frame_count >= hold_frames) begin
              fired = 1'b1;
              fade_phase = PH_IN;
              frame_count = '0;
            end
          end
          PH_IN: begin
            fade_frame(in_len);
            if (frame_count >= in_len) begin
              fade_phase = PH_IDLE;
              alpha_now = '0;
              progress_now = PROG_FULL;
            end
          end
          default: ;
        endcase
      end
      CMD_START_OUT: begin
        fade_phase = PH_OUT;
        out_len = dur;
        frame_count = '0;
        progress_now = '0;
      end
      CMD_START_IN: begin
        fade_phase = PH_IN;
        in_len = dur;
        frame_count = '0;
        progress_now = '0;
      end
      CMD_SKIP: begin
        if (fade_phase != PH_IDLE) begin
          if (fade_phase == PH_OUT) begin
            fired = 1'b1;
            fade_phase = PH_IN;
            frame_count = in_len;
          end else begin
            fired = (fade_phase == PH_HOLD);
            fade_phase = PH_IDLE;
          end
          alpha_now = '0;
          progress_now = PROG_FULL;
        end
      end
      CMD_RESET: begin
        fade_phase = PH_IDLE;
        frame_count = '0;
        alpha_now = '0;
        progress_now = '0;
      end
      default: ;
    endcase
    expected_results.push_back('{alpha: alpha_now, progress: progress_now,
                                 phase: fade_phase, callback_fired: fired});
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_results.size() == 0) begin
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("unexpected word: alpha %0d progress %0d phase %0d callback %0b",
                 got.alpha, got.progress, got.phase, got.callback_fired);
      end
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      if (got.alpha != want.alpha || got.progress != want.progress ||
          got.phase != want.phase || got.callback_fired != want.callback_fired) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("mismatch on word %0d: alpha %0d/%0d progress %0d/%0d phase %0d/%0d cb %0b/%0b",
                   results_checked, want.alpha, got.alpha, want.progress, got.progress,
                   want.phase, got.phase, want.callback_fired, got.callback_fired);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cmd_valid <= 1'b1;
        cmd_word <= pending_words.pop_front();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        step_sequencer(cmd_word);
        words_sent++;
      end
      if (res_valid && !res_stall) begin
        check_result(res_word);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic apb_access(input logic idx, input logic wr, input logic [15:0] val,
                            output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(input logic idx, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(idx, 1'b0, 16'h0000, rd);
    if (rd[15:0] !== val) begin
      errors++;
      if (errors <= REPORT_MAX) begin
        $display("register %0d read back %0d, expected %0d", idx, rd[15:0], val);
      end
    end
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    logic [31:0] rd;
    apb_access(idx, 1'b1, val, rd);
    if (idx == REG_HOLD) begin
      hold_frames = val;
    end else begin
      speed_q8 = val;
    end
    reg_writes++;
    check_reg(idx, val);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      1: begin gap_pct = 58; stall_pct = 0; end
      2: begin gap_pct = 0; stall_pct = 58; end
      3: begin gap_pct = 27; stall_pct = 27; end
      default: begin gap_pct = 0; stall_pct = 0; end
    endcase
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || cmd_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_word(input logic [2:0] c, input logic [15:0] d);
    pending_words.push_back('{cmd: c, duration: d});
    words_queued++;
  endtask

  task automatic push_ticks(input int n);
    logic [15:0] d;
    repeat (n) begin
      d = $urandom_range(65535);
      push_word(CMD_TICK, d);
    end
  endtask

  function automatic int frames_of(input logic [15:0] d);
    return (d == 0) ? int'(DEFAULT_LEN) : int'(d);
  endfunction

  function automatic logic [15:0] pick_length();
    int r;
    logic [15:0] d;
    r = $urandom_range(99);
    if (r < 10) d = 16'd0;
    else if (r < 75) d = $urandom_range(12, 1);
    else if (r < 90) d = $urandom_range(40, 13);
    else if (r < 94) d = 16'hFFFF;
    else d = $urandom_range(65535, 41);
    return d;
  endfunction

  task automatic queue_sequence();
    int r;
    int span;
    int cut;
    logic [15:0] d_out;
    logic [15:0] d_in;
    logic [15:0] d;
    logic [2:0] c;
    r = $urandom_range(99);
    if (r < 15) begin
      repeat ($urandom_range(6, 1)) begin
        c = $urandom_range(CMD_LAST);
        d = $urandom_range(65535);
        push_word(c, d);
      end
    end else begin
      d_out = pick_length();
      d_in = pick_length();
      push_word(CMD_START_IN, d_in);
      span = frames_of(d_in) + 2;
      if (r >= 35) begin
        push_word(CMD_START_OUT, d_out);
        span = span + frames_of(d_out) + hold_frames;
      end
      if (span > 70) span = $urandom_range(40, 1);
      cut = $urandom_range(span);
      r = $urandom_range(99);
      d = $urandom_range(65535);
      if (r < 25) begin
        push_ticks(cut);
        push_word(CMD_SKIP, d);
        push_ticks(span - cut);
      end else if (r < 35) begin
        push_ticks(cut);
        c = (r < 30) ? CMD_RESET : 3'($urandom_range(CMD_LAST, CMD_RESET + 3'd1));
        push_word(c, d);
      end else begin
        push_ticks(span);
      end
    end
  endtask

  initial begin
    logic [15:0] h;
    logic [15:0] s;
    clear_sequencer();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    check_reg(REG_HOLD, 16'd0);
    check_reg(REG_SPEED, SPEED_ONE);

    // idle commands, skips in both fades, shortest and longest lengths
    push_word(CMD_TICK, 16'hFFFF);
    push_word(CMD_SKIP, 16'h0000);
    push_word(CMD_RESET + 3'd1, 16'hFFFF);
    push_word(CMD_RESET + 3'd2, 16'h5A5A);
    push_word(CMD_LAST, 16'h0000);
    push_word(CMD_START_OUT, 16'd0);
    push_ticks(2);
    push_word(CMD_SKIP, 16'hA5A5);
    push_ticks(1);
    push_word(CMD_START_IN, 16'hFFFF);
    push_ticks(1);
    push_word(CMD_SKIP, 16'd0);
    push_word(CMD_START_OUT, 16'd1);
    push_ticks(2);
    push_word(CMD_RESET, 16'hFFFF);
    push_word(CMD_START_IN, 16'd1);
    push_ticks(1);
    push_word(CMD_START_OUT, 16'hFFFF);
    push_ticks(1);
    push_word(CMD_RESET, 16'd0);
    wait_idle();

    // hold phase, then skip out of hold
    write_reg(REG_HOLD, 16'd2);
    push_word(CMD_START_OUT, 16'd2);
    push_ticks(6);
    push_word(CMD_START_OUT, 16'd1);
    push_ticks(1);
    push_word(CMD_SKIP, 16'd0);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin h = 16'd0; s = SPEED_ONE; end
        1: begin h = 16'd3; s = 16'd0; end
        2: begin h = 16'd1; s = 16'd1; end
        3: begin h = 16'd0; s = 16'hFFFF; end
        4: begin h = 16'd5; s = 16'd128; end
        5: begin h = 16'd2; s = 16'd300; end
        6: begin h = $urandom_range(6); s = $urandom_range(65535); end
        default: begin h = 16'd4; s = 16'd512; end
      endcase
      write_reg(REG_HOLD, h);
      write_reg(REG_SPEED, s);
      set_idling(p % 4);
      words_queued = 0;
      while (words_queued < PHASE_WORDS) queue_sequence();
      wait_idle();
    end

    // long hold at the highest speed, then a skip out of hold
    set_idling(0);
    write_reg(REG_HOLD, 16'd20);
    write_reg(REG_SPEED, 16'hFFFF);
    push_word(CMD_START_IN, 16'd3);
    push_word(CMD_START_OUT, 16'd1);
    push_ticks(1 + 20 + 4);
    push_word(CMD_START_OUT, 16'd2);
    push_ticks(5);
    push_word(CMD_SKIP, 16'hFFFF);
    wait_idle();

    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0d results never arrived", expected_results.size());
    end
    $display("summary: %0d words sent, %0d results checked, %0d register writes",
             words_sent, results_checked, reg_writes);
    $display("summary: fades, hold, skips and resets under four idle and stall mixes");
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
